>>> rtl/fmm_child_interpolation_operator_unit_assert.svh
// assertion macros shared by the child interpolation operator rtl
`ifndef FMM_CHILD_INTERPOLATION_OPERATOR_UNIT_ASSERT_SVH
`define FMM_CHILD_INTERPOLATION_OPERATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define FCIO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define FCIO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fcio_pkg.sv
// types, constants and lookup functions for the child interpolation operator
package fcio_pkg;

    localparam int VALUE_WIDTH  = 24;
    localparam int FRAC_BITS    = VALUE_WIDTH - 4;
    localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;
    localparam int QUOT_WIDTH   = PROD_WIDTH - FRAC_BITS;
    localparam int MAX_ORDER    = 8;
    localparam int ORDER_WIDTH  = 4;
    localparam int INDEX_WIDTH  = 9;
    localparam int DIGIT_WIDTH  = 3;
    localparam int ADDR_WIDTH   = 6;
    localparam int TABLE_DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int CHILD_WIDTH  = 3;
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_WIDTH  = RECIP_SHIFT + 1;
    localparam int CUBE_WIDTH   = INDEX_WIDTH + 1;
    localparam int NUM_STAGES   = 9;
    localparam int MIRROR_X_BIT = 2;
    localparam int MIRROR_Y_BIT = 1;
    localparam int MIRROR_Z_BIT = 0;
    localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(4);

    // item kinds
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef struct packed {
        t_func                         func;
        logic [ADDR_WIDTH-1:0]         table_index;
        logic signed [VALUE_WIDTH-1:0] table_value;
        logic [CHILD_WIDTH-1:0]        child;
        logic [INDEX_WIDTH-1:0]        row;
        logic [INDEX_WIDTH-1:0]        col;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] operator_value;
        logic                          in_range;
    } t_out_item;

    // ceil(2^16 / n): x / n == (x * recip) >> 16 for every 9-bit x
    function automatic logic [RECIP_WIDTH-1:0] f_recip(input logic [ORDER_WIDTH-1:0] n);
        logic [RECIP_WIDTH-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

    // n cubed, the operator dimension
    function automatic logic [CUBE_WIDTH-1:0] f_cube(input logic [ORDER_WIDTH-1:0] n);
        logic [CUBE_WIDTH-1:0] c;
        case (n)
            4'd1:    c = 10'd1;
            4'd2:    c = 10'd8;
            4'd3:    c = 10'd27;
            4'd4:    c = 10'd64;
            4'd5:    c = 10'd125;
            4'd6:    c = 10'd216;
            4'd7:    c = 10'd343;
            4'd8:    c = 10'd512;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/fmm_child_interpolation_operator_unit.sv
// Child-octant interpolation operator: a nine-stage pipeline that takes one item per
// cycle unless o_in_stall is high and returns a result for each query. Stages one to
// three split row and column into x, y and z digits by reciprocal multiplication, stage
// four forms the three table addresses, stage five reads three copies of the 64-entry
// table (loads write all copies there, so loads and queries keep their order), stages
// six to nine do two rounded and saturated Q3.20 multiplies. Stall ripples back only
// through full stages, so bubbles are squeezed out and the input keeps taking items
// while a result waits at the output. Loads give no result; order is n, clamped to 8.
`include "fmm_child_interpolation_operator_unit_assert.svh"

module fmm_child_interpolation_operator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fcio_pkg::ORDER_WIDTH-1:0]    i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fcio_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fcio_pkg::t_out_item                 o_out_data
);
    import fcio_pkg::*;

    // rounded, saturated scale-down of a full product
    function automatic logic signed [VALUE_WIDTH-1:0] f_round_sat(
        input logic signed [PROD_WIDTH-1:0] p
    );
        logic [PROD_WIDTH-1:0]  mag;
        logic [PROD_WIDTH-1:0]  sum;
        logic [QUOT_WIDTH-1:0]  q;
        logic [QUOT_WIDTH-1:0]  lim;
        logic [VALUE_WIDTH-1:0] m;
        mag = p[PROD_WIDTH-1] ? (~$unsigned(p) + PROD_WIDTH'(1)) : $unsigned(p);
        sum = mag + (PROD_WIDTH'(1) << (FRAC_BITS - 1));
        q   = sum[PROD_WIDTH-1:FRAC_BITS];
        lim = p[PROD_WIDTH-1] ? (QUOT_WIDTH'(1) << (VALUE_WIDTH - 1))
                              : ((QUOT_WIDTH'(1) << (VALUE_WIDTH - 1)) - QUOT_WIDTH'(1));
        if (q > lim) begin
            q = lim;
        end
        m = q[VALUE_WIDTH-1:0];
        return p[PROD_WIDTH-1] ? $signed(~m + VALUE_WIDTH'(1)) : $signed(m);
    endfunction

    // table address j*n+i, or the mirrored entry
    function automatic logic [ADDR_WIDTH-1:0] f_addr(
        input logic [ORDER_WIDTH-1:0] n,
        input logic [DIGIT_WIDTH-1:0] i,
        input logic [DIGIT_WIDTH-1:0] j,
        input logic                   mirror
    );
        logic [ADDR_WIDTH-1:0] nn;
        logic [ADDR_WIDTH-1:0] ii;
        logic [ADDR_WIDTH-1:0] jj;
        nn = ADDR_WIDTH'(n);
        if (mirror) begin
            ii = nn - ADDR_WIDTH'(1) - ADDR_WIDTH'(i);
            jj = nn - ADDR_WIDTH'(1) - ADDR_WIDTH'(j);
        end else begin
            ii = ADDR_WIDTH'(i);
            jj = ADDR_WIDTH'(j);
        end
        return jj * nn + ii;
    endfunction

    // configuration and derived order values
    logic [ORDER_WIDTH-1:0] r_order;
    logic [ORDER_WIDTH-1:0] w_n;
    logic [RECIP_WIDTH-1:0] w_recip;
    logic [CUBE_WIDTH-1:0]  w_cube;

    // pipeline control
    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] n_vld;
    logic [NUM_STAGES:1] adv;

    // stage 1
    logic [INDEX_WIDTH+RECIP_WIDTH-1:0] w_row_p1;
    logic [INDEX_WIDTH+RECIP_WIDTH-1:0] w_col_p1;
    t_func                              r_func1;
    logic [ADDR_WIDTH-1:0]              r_tidx1;
    logic signed [VALUE_WIDTH-1:0]      r_tval1;
    logic [CHILD_WIDTH-1:0]             r_child1;
    logic                               r_inr1;
    logic [DIGIT_WIDTH-1:0]             r_row1;
    logic [DIGIT_WIDTH-1:0]             r_col1;
    logic [INDEX_WIDTH-1:0]             r_rq1;
    logic [INDEX_WIDTH-1:0]             r_cq1;

    // stage 2
    logic [INDEX_WIDTH+RECIP_WIDTH-1:0] w_row_p2;
    logic [INDEX_WIDTH+RECIP_WIDTH-1:0] w_col_p2;
    logic [DIGIT_WIDTH-1:0]             w_row_m2;
    logic [DIGIT_WIDTH-1:0]             w_col_m2;
    t_func                              r_func2;
    logic [ADDR_WIDTH-1:0]              r_tidx2;
    logic signed [VALUE_WIDTH-1:0]      r_tval2;
    logic [CHILD_WIDTH-1:0]             r_child2;
    logic                               r_inr2;
    logic [DIGIT_WIDTH-1:0]             r_rz2;
    logic [DIGIT_WIDTH-1:0]             r_cz2;
    logic [DIGIT_WIDTH-1:0]             r_rq1_2;
    logic [DIGIT_WIDTH-1:0]             r_cq1_2;
    logic [DIGIT_WIDTH-1:0]             r_rq2;
    logic [DIGIT_WIDTH-1:0]             r_cq2;

    // stage 3
    logic [DIGIT_WIDTH-1:0]             w_row_m3;
    logic [DIGIT_WIDTH-1:0]             w_col_m3;
    t_func                              r_func3;
    logic [ADDR_WIDTH-1:0]              r_tidx3;
    logic signed [VALUE_WIDTH-1:0]      r_tval3;
    logic [CHILD_WIDTH-1:0]             r_child3;
    logic                               r_inr3;
    logic [DIGIT_WIDTH-1:0]             r_rx3;
    logic [DIGIT_WIDTH-1:0]             r_ry3;
    logic [DIGIT_WIDTH-1:0]             r_rz3;
    logic [DIGIT_WIDTH-1:0]             r_cx3;
    logic [DIGIT_WIDTH-1:0]             r_cy3;
    logic [DIGIT_WIDTH-1:0]             r_cz3;

    // stage 4
    t_func                              r_func4;
    logic [ADDR_WIDTH-1:0]              r_tidx4;
    logic signed [VALUE_WIDTH-1:0]      r_tval4;
    logic                               r_inr4;
    logic [ADDR_WIDTH-1:0]              r_addr_x4;
    logic [ADDR_WIDTH-1:0]              r_addr_y4;
    logic [ADDR_WIDTH-1:0]              r_addr_z4;

    // stage 5: three table copies, one per axis
    logic signed [VALUE_WIDTH-1:0]      r_mem_x [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0]      r_mem_y [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0]      r_mem_z [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0]      r_ax5;
    logic signed [VALUE_WIDTH-1:0]      r_ay5;
    logic signed [VALUE_WIDTH-1:0]      r_az5;
    logic                               r_inr5;

    // stages 6 to 9
    logic signed [PROD_WIDTH-1:0]       r_p6;
    logic signed [VALUE_WIDTH-1:0]      r_az6;
    logic                               r_inr6;
    logic signed [VALUE_WIDTH-1:0]      r_t7;
    logic signed [VALUE_WIDTH-1:0]      r_az7;
    logic                               r_inr7;
    logic signed [PROD_WIDTH-1:0]       r_p8;
    logic                               r_inr8;
    t_out_item                          r_out9;

    // order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    assign w_n     = (r_order > ORDER_WIDTH'(MAX_ORDER)) ? ORDER_WIDTH'(MAX_ORDER) : r_order;
    assign w_recip = f_recip(w_n);
    assign w_cube  = f_cube(w_n);

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        adv[NUM_STAGES] = !r_vld[NUM_STAGES] || !i_out_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    // valid bits follow the data; loads leave after the table stage
    always_comb begin
        n_vld[1] = i_in_valid;
        for (int k = 2; k <= NUM_STAGES; k++) begin
            n_vld[k] = r_vld[k-1];
        end
        n_vld[5] = r_vld[4] && (r_func4 == FUNC_QUERY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_in_stall  = !adv[1];
    assign o_out_valid = r_vld[NUM_STAGES];
    assign o_out_data  = r_out9;

    // stage 1: range check and first quotient by n
    assign w_row_p1 = {{RECIP_WIDTH{1'b0}}, i_in_data.row} * {{INDEX_WIDTH{1'b0}}, w_recip};
    assign w_col_p1 = {{RECIP_WIDTH{1'b0}}, i_in_data.col} * {{INDEX_WIDTH{1'b0}}, w_recip};

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_func1  <= i_in_data.func;
            r_tidx1  <= i_in_data.table_index;
            r_tval1  <= i_in_data.table_value;
            r_child1 <= i_in_data.child;
            r_inr1   <= ({1'b0, i_in_data.row} < w_cube) && ({1'b0, i_in_data.col} < w_cube);
            r_row1   <= i_in_data.row[DIGIT_WIDTH-1:0];
            r_col1   <= i_in_data.col[DIGIT_WIDTH-1:0];
            r_rq1    <= w_row_p1[RECIP_SHIFT +: INDEX_WIDTH];
            r_cq1    <= w_col_p1[RECIP_SHIFT +: INDEX_WIDTH];
        end
    end

    // stage 2: z digit as remainder, second quotient gives x
    assign w_row_p2 = {{RECIP_WIDTH{1'b0}}, r_rq1} * {{INDEX_WIDTH{1'b0}}, w_recip};
    assign w_col_p2 = {{RECIP_WIDTH{1'b0}}, r_cq1} * {{INDEX_WIDTH{1'b0}}, w_recip};
    assign w_row_m2 = r_rq1[DIGIT_WIDTH-1:0] * w_n[DIGIT_WIDTH-1:0];
    assign w_col_m2 = r_cq1[DIGIT_WIDTH-1:0] * w_n[DIGIT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_func2  <= r_func1;
            r_tidx2  <= r_tidx1;
            r_tval2  <= r_tval1;
            r_child2 <= r_child1;
            r_inr2   <= r_inr1;
            r_rz2    <= r_row1 - w_row_m2;
            r_cz2    <= r_col1 - w_col_m2;
            r_rq1_2  <= r_rq1[DIGIT_WIDTH-1:0];
            r_cq1_2  <= r_cq1[DIGIT_WIDTH-1:0];
            r_rq2    <= w_row_p2[RECIP_SHIFT +: DIGIT_WIDTH];
            r_cq2    <= w_col_p2[RECIP_SHIFT +: DIGIT_WIDTH];
        end
    end

    // stage 3: y digit as remainder of the first quotient
    assign w_row_m3 = r_rq2 * w_n[DIGIT_WIDTH-1:0];
    assign w_col_m3 = r_cq2 * w_n[DIGIT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_func3  <= r_func2;
            r_tidx3  <= r_tidx2;
            r_tval3  <= r_tval2;
            r_child3 <= r_child2;
            r_inr3   <= r_inr2;
            r_rx3    <= r_rq2;
            r_ry3    <= r_rq1_2 - w_row_m3;
            r_rz3    <= r_rz2;
            r_cx3    <= r_cq2;
            r_cy3    <= r_cq1_2 - w_col_m3;
            r_cz3    <= r_cz2;
        end
    end

    // stage 4: table addresses, mirrored per child octant bit
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_func4   <= r_func3;
            r_tidx4   <= r_tidx3;
            r_tval4   <= r_tval3;
            r_inr4    <= r_inr3;
            r_addr_x4 <= f_addr(w_n, r_rx3, r_cx3, r_child3[MIRROR_X_BIT]);
            r_addr_y4 <= f_addr(w_n, r_ry3, r_cy3, r_child3[MIRROR_Y_BIT]);
            r_addr_z4 <= f_addr(w_n, r_rz3, r_cz3, r_child3[MIRROR_Z_BIT]);
        end
    end

    // stage 5: table write for loads, registered reads for queries
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            if (r_vld[4] && (r_func4 == FUNC_LOAD)) begin
                r_mem_x[r_tidx4] <= r_tval4;
                r_mem_y[r_tidx4] <= r_tval4;
                r_mem_z[r_tidx4] <= r_tval4;
            end
            r_ax5  <= r_mem_x[r_addr_x4];
            r_ay5  <= r_mem_y[r_addr_y4];
            r_az5  <= r_mem_z[r_addr_z4];
            r_inr5 <= r_inr4;
        end
    end

    // stage 6: y times x
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_p6   <= r_ay5 * r_ax5;
            r_az6  <= r_az5;
            r_inr6 <= r_inr5;
        end
    end

    // stage 7: round and saturate the partial product
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_t7   <= f_round_sat(r_p6);
            r_az7  <= r_az6;
            r_inr7 <= r_inr6;
        end
    end

    // stage 8: z times partial product
    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_p8   <= r_az7 * r_t7;
            r_inr8 <= r_inr7;
        end
    end

    // stage 9: final rounding, zero when out of range
    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            r_out9.operator_value <= r_inr8 ? f_round_sat(r_p8) : '0;
            r_out9.in_range       <= r_inr8;
        end
    end

    // checks
    `FCIO_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, &r_vld, "input stalled with a bubble in the pipeline")
    `FCIO_ASSERT_NEXT(a_load_leaves, adv[5] && r_vld[4] && (r_func4 == FUNC_LOAD), !r_vld[5], "load transfer reached the multiply stages")
    `FCIO_ASSERT_IMPL(a_digit_range, r_vld[3] && r_inr3, (ORDER_WIDTH'(r_rx3) < w_n) && (ORDER_WIDTH'(r_ry3) < w_n) && (ORDER_WIDTH'(r_rz3) < w_n) && (ORDER_WIDTH'(r_cx3) < w_n) && (ORDER_WIDTH'(r_cy3) < w_n) && (ORDER_WIDTH'(r_cz3) < w_n), "digit not below order for an in-range query")

endmodule
